// ===== hw/rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the serial frame deframer
// Item and status types passed between the front, queue and back stages,
// plus the sync, escape and header constants of the frame format.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Frame format bytes
  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] ESC_BYTE  = 8'h55;

  // Width of the decoded total length (16-bit length plus header)
  localparam int unsigned TOTAL_W = 17;

  // Header size and positions of the length bytes within a frame
  localparam logic [TOTAL_W-1:0] HDR_BYTES  = 17'd4;
  localparam logic [TOTAL_W-1:0] LEN_HI_IDX = 17'd2;
  localparam logic [TOTAL_W-1:0] LEN_LO_IDX = 17'd3;
  // Index reported with the second sync byte of a new frame
  localparam logic [TOTAL_W-1:0] SYNC_IDX   = 17'd1;
  // Count held right after a frame opens
  localparam logic [TOTAL_W-1:0] OPEN_COUNT = 17'd2;

  // Frame end status codes
  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_GOOD     = 2'd1,
    ST_BAD      = 2'd2,
    ST_OVERSIZE = 2'd3
  } sfd_status_t;

  // Classified input item
  typedef struct packed {
    logic [7:0] data;
    logic       is_sync;
    logic       is_esc;
  } sfd_item_t;

  // Queue fill status seen by the stages on either side
  typedef struct packed {
    logic full;
    logic empty;
  } sfd_qstat_t;

endpackage

// ===== hw/rtl/serial_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_deframer: sync/length/checksum frame decoder
// Finds frames opened by an FF FF pair, drops FF 55 escapes, streams every
// stored byte with its index and flags each frame end as good, bad, aborted
// or oversize.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                    Payload
//  in_       in   tvalid/tready/tdata[7:0]   rx_byte
//  out_      out  tvalid/tready/tdata[31:0]  out_byte, out_index, frame_length
//                 tlast, tuser[2:0]          frame_end; out_valid, frame_status
//
//  One result per input byte, one byte per cycle sustained while out_tready is high.
//  After its byte is accepted, a result passes the input register, the queue
//  and the result register.
//  The frame stage updates its count, length and checksum together, which
//  sets the rate. Synchronous reset empties the queue and all frame state.
//  Output stalls back up through the two-entry queue to in_tready.
// ----------------------------------------------------------------------------
module serial_frame_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [15:8] out_index,
                                  // [24:16] frame_length, [31:25] zero
  output logic        out_tlast,  // frame_end
  output logic [2:0]  out_tuser   // [0] out_valid, [2:1] frame_status
);

  sfd_pkg::sfd_qstat_t q_stat;
  sfd_pkg::sfd_item_t  push_item, pop_item;
  logic                push, pop;

  sfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  sfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  sfd_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_item   (pop_item),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/sfd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_front: input stage
// Accepts received bytes, tags sync and escape codes, and hands the tagged
// item to the queue.
// ----------------------------------------------------------------------------
module sfd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  sfd_pkg::sfd_qstat_t  q_stat,
  output logic                 push,
  output sfd_pkg::sfd_item_t   push_item
);

  logic                vld_r, vld_nxt;
  sfd_pkg::sfd_item_t  item_r;
  logic                take;

  // Hand off to the queue whenever it has room
  assign push      = vld_r && !q_stat.full;
  assign push_item = item_r;
  assign in_tready = !vld_r || !q_stat.full;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  // Hold valid flag; classify and capture the byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (take) begin
      item_r.data    <= in_tdata;
      item_r.is_sync <= (in_tdata == sfd_pkg::SYNC_BYTE);
      item_r.is_esc  <= (in_tdata == sfd_pkg::ESC_BYTE);
    end
  end

endmodule

// ===== hw/rtl/sfd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_queue: two-entry item queue
// Decouples the input stage from the frame stage so each can stall alone.
// ----------------------------------------------------------------------------
module sfd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sfd_pkg::sfd_item_t  push_item,
  input  logic                pop,
  output sfd_pkg::sfd_item_t  pop_item,
  output sfd_pkg::sfd_qstat_t q_stat
);

  sfd_pkg::sfd_item_t  mem_r [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/sfd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_back: frame tracking stage
// Runs the frame state for each queued item (sync pairs, escapes, length,
// checksum, oversize) and drives the registered result channel.
// ----------------------------------------------------------------------------
module sfd_back #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sfd_pkg::sfd_item_t  pop_item,
  input  sfd_pkg::sfd_qstat_t q_stat,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // [7:0] out_byte, [15:8] out_index,
                                          // [24:16] frame_length, [31:25] zero
  output logic                out_tlast,  // frame_end
  output logic [2:0]          out_tuser   // [0] out_valid, [2:1] frame_status
);

  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned TW = sfd_pkg::TOTAL_W;
  localparam logic [TW-1:0] MAX_TOTAL = TW'(MAX_FRAME_BYTES);

  // Frame state
  logic               in_frame_r, in_frame_nxt;
  logic               prev_ff_r, prev_ff_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [7:0]         len_hi_r, len_hi_nxt;
  logic [TW-1:0]      exp_total_r, exp_total_nxt;
  logic [7:0]         sum_r, sum_nxt;

  // Result register
  logic               ovld_r;
  logic               o_flag_r, o_flag_nxt;
  logic [7:0]         o_byte_r, o_byte_nxt;
  logic [7:0]         o_index_r, o_index_nxt;
  logic               o_end_r, o_end_nxt;
  sfd_pkg::sfd_status_t o_stat_r, o_stat_nxt;
  logic [8:0]         o_len_r, o_len_nxt;

  // Working values
  logic               pair, esc;
  logic [TW-1:0]      cnt_ext, cnt_inc_ext, exp_now;
  logic [CW-1:0]      cnt_inc;
  logic [7:0]         b;

  assign pop = !q_stat.empty && (!ovld_r || out_tready);
  assign b   = pop_item.data;

  assign pair        = prev_ff_r && pop_item.is_sync;
  assign esc         = prev_ff_r && pop_item.is_esc;
  assign cnt_inc     = count_r + CW'(1);
  assign cnt_ext     = TW'(count_r);
  assign cnt_inc_ext = TW'(cnt_inc);
  assign exp_now     = (cnt_ext == sfd_pkg::LEN_LO_IDX) ?
                       ({len_hi_r, b} + sfd_pkg::HDR_BYTES) : exp_total_r;

  // Decide the frame step for the item at the head of the queue
  always_comb begin
    in_frame_nxt  = in_frame_r;
    prev_ff_nxt   = pop_item.is_sync;
    count_nxt     = count_r;
    len_hi_nxt    = len_hi_r;
    exp_total_nxt = exp_total_r;
    sum_nxt       = sum_r;
    o_flag_nxt    = 1'b0;
    o_byte_nxt    = 8'd0;
    o_index_nxt   = 8'd0;
    o_end_nxt     = 1'b0;
    o_stat_nxt    = sfd_pkg::ST_NONE;
    o_len_nxt     = 9'd0;

    if (pair) begin
      // Open a frame, or restart once past the header
      if (!in_frame_r || (cnt_ext > sfd_pkg::HDR_BYTES)) begin
        if (in_frame_r) begin
          o_end_nxt = 1'b1;
          o_len_nxt = cnt_ext[8:0];
        end
        in_frame_nxt  = 1'b1;
        count_nxt     = CW'(sfd_pkg::OPEN_COUNT);
        len_hi_nxt    = 8'd0;
        exp_total_nxt = '0;
        sum_nxt       = 8'd0;
        o_flag_nxt    = 1'b1;
        o_byte_nxt    = sfd_pkg::SYNC_BYTE;
        o_index_nxt   = sfd_pkg::SYNC_IDX[7:0];
      end
    end else if (esc) begin
      // Drop the escape byte
    end else if (in_frame_r) begin
      if (cnt_ext >= MAX_TOTAL) begin
        // Buffer full: abort as oversize
        o_end_nxt    = 1'b1;
        o_stat_nxt   = sfd_pkg::ST_OVERSIZE;
        o_len_nxt    = cnt_ext[8:0];
        in_frame_nxt = 1'b0;
        count_nxt    = '0;
        prev_ff_nxt  = 1'b0;
      end else begin
        count_nxt   = cnt_inc;
        o_flag_nxt  = 1'b1;
        o_byte_nxt  = b;
        o_index_nxt = cnt_ext[7:0];
        if (cnt_ext == sfd_pkg::LEN_HI_IDX) begin
          len_hi_nxt = b;
        end
        if (cnt_ext == sfd_pkg::LEN_LO_IDX) begin
          exp_total_nxt = exp_now;
        end
        if ((cnt_inc_ext > sfd_pkg::HDR_BYTES) && (cnt_inc_ext == exp_now)) begin
          // Last byte: compare checksum
          o_end_nxt    = 1'b1;
          o_stat_nxt   = (sum_r == b) ? sfd_pkg::ST_GOOD : sfd_pkg::ST_BAD;
          o_len_nxt    = cnt_inc_ext[8:0];
          in_frame_nxt = 1'b0;
          count_nxt    = '0;
          prev_ff_nxt  = 1'b0;
        end else begin
          if (cnt_ext >= sfd_pkg::LEN_HI_IDX) begin
            sum_nxt = sum_r + b;
          end
          if ((cnt_ext == sfd_pkg::LEN_LO_IDX) && (exp_now > MAX_TOTAL)) begin
            // Declared length does not fit
            o_end_nxt    = 1'b1;
            o_stat_nxt   = sfd_pkg::ST_OVERSIZE;
            o_len_nxt    = cnt_inc_ext[8:0];
            in_frame_nxt = 1'b0;
            count_nxt    = '0;
            prev_ff_nxt  = 1'b0;
          end
        end
      end
    end
  end

  // Hold frame state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      prev_ff_r   <= 1'b0;
      count_r     <= '0;
      len_hi_r    <= 8'd0;
      exp_total_r <= '0;
      sum_r       <= 8'd0;
      ovld_r      <= 1'b0;
    end else begin
      if (pop) begin
        in_frame_r  <= in_frame_nxt;
        prev_ff_r   <= prev_ff_nxt;
        count_r     <= count_nxt;
        len_hi_r    <= len_hi_nxt;
        exp_total_r <= exp_total_nxt;
        sum_r       <= sum_nxt;
        ovld_r      <= 1'b1;
      end else if (out_tready) begin
        ovld_r      <= 1'b0;
      end
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      o_flag_r  <= o_flag_nxt;
      o_byte_r  <= o_byte_nxt;
      o_index_r <= o_index_nxt;
      o_end_r   <= o_end_nxt;
      o_stat_r  <= o_stat_nxt;
      o_len_r   <= o_len_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {7'd0, o_len_r, o_index_r, o_byte_r};
  assign out_tlast  = o_end_r;
  assign out_tuser  = {o_stat_r, o_flag_r};

endmodule

// ===== hw/rtl/sfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker: port-level checks for the serial frame deframer
// Watches the result channel for stall stability and field consistency.
// ----------------------------------------------------------------------------
module sfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic [2:0]  out_tuser
);

  // Result channel empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // A nonzero status only comes with a frame end
  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] != 2'd0) |-> out_tlast)
    else $error("status without frame end");

  // Length is zero except at a frame end
  a_len_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tdata[24:16] == 9'd0))
    else $error("frame length outside frame end");

  // Byte and index are zero when nothing was stored
  a_data_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[15:0] == 16'd0))
    else $error("byte data without stored flag");

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
